FILE: rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the signed integer to decimal ASCII unit.
// Depends on nothing; used by signed_int_to_decimal_ascii_unit.
package sitda_pkg;

  localparam int CHAR_W = 8;
  localparam int BCD_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  localparam logic [BCD_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_W-1:0] BCD_ADJ     = 4'd3;

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// Converts one two's complement integer into decimal ASCII characters.
// Depends on sitda_pkg for character codes and BCD digit constants.
//
// Usage: a request on the input channel (in_valid, in_stall, value) carries
// one integer of WIDTH bits. The output channel (out_valid, out_stall,
// character, last) returns its decimal text, most significant character
// first: a '-' for a negative value, then the digits with no leading zeros.
// The flag last marks the final digit; zero gives the single character '0'.
// One item is handled at a time: in_stall is high from the accepting edge
// until the last character has been loaded into the output register.
// The magnitude is shifted one bit per cycle into a BCD register with the
// add-three adjustment, WIDTH bits in all. The BCD register is then walked
// one decimal digit per cycle while the output is not stalled, NDIG =
// WIDTH*3/10+1 digits, skipping leading zeros; a '-' for a negative value
// goes out before the first digit.
// A stall on the output holds the character register and pauses the digit
// walk; the conversion phase runs on regardless. The next request is taken
// while the final character still waits in the output register.
// Reset is synchronous and clears the sequencer and the output valid flag.
module signed_int_to_decimal_ascii_unit #(
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [WIDTH-1:0]        value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]   character,
  output logic                           last
);

  localparam int NDIG  = WIDTH * 3 / 10 + 1;
  localparam int BCDW  = NDIG * sitda_pkg::BCD_W;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int DIG_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);
  localparam logic [DIG_W-1:0] DIG_LAST = DIG_W'(NDIG - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [WIDTH-1:0]               mag;
  logic [BCDW-1:0]                bcd;
  logic [BCDW-1:0]                bcd_adj;
  logic [CNT_W-1:0]               bitcnt;
  logic [DIG_W-1:0]               digcnt;
  logic                           sign_pending;
  logic                           started;
  logic [WIDTH-1:0]               value_u;
  logic [sitda_pkg::BCD_W-1:0]    top_digit;
  logic                           out_free;
  logic                           emit_load;

  assign value_u   = value;
  assign top_digit = bcd[BCDW-1 -: sitda_pkg::BCD_W];
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign emit_load = (state == ST_EMIT) && out_free &&
                     (sign_pending || top_digit != '0 || started || digcnt == DIG_LAST);

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] >= sitda_pkg::BCD_ADJ_MIN) begin
        bcd_adj[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] =
          bcd[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] + sitda_pkg::BCD_ADJ;
      end else begin
        bcd_adj[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W] =
          bcd[i*sitda_pkg::BCD_W +: sitda_pkg::BCD_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mag          <= value_u[WIDTH-1] ? (~value_u + WIDTH'(1)) : value_u;
            sign_pending <= value_u[WIDTH-1];
            bcd          <= '0;
            bitcnt       <= '0;
            digcnt       <= '0;
            started      <= 1'b0;
            state        <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd    <= {bcd_adj[BCDW-2:0], mag[WIDTH-1]};
          mag    <= {mag[WIDTH-2:0], 1'b0};
          bitcnt <= bitcnt + CNT_W'(1);
          if (bitcnt == CNT_LAST) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (sign_pending) begin
              character    <= sitda_pkg::CHAR_MINUS;
              last         <= 1'b0;
              sign_pending <= 1'b0;
            end else begin
              bcd    <= {bcd[BCDW-sitda_pkg::BCD_W-1:0], {sitda_pkg::BCD_W{1'b0}}};
              digcnt <= digcnt + DIG_W'(1);
              if (top_digit != '0 || started || digcnt == DIG_LAST) begin
                character <= sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(top_digit);
                last      <= (digcnt == DIG_LAST);
                started   <= 1'b1;
              end
              if (digcnt == DIG_LAST) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
